### hdl/bmpd_pkg.sv
`default_nettype none

package bmpd_pkg;

  // field widths fixed by the item format
  localparam int unsigned CoordW   = 12;
  localparam int unsigned ByteCntW = 14;
  localparam int unsigned RgbW     = 24;

  // widest row the decoder walks; wider settings are clamped to it
  localparam int unsigned MAX_WIDTH = 4095;

  // default palette size
  localparam int unsigned PALETTE_DEPTH_DEF = 256;

  // decoupling queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  // pixel modes
  localparam logic [1:0] MODE_4BPP  = 2'd0;
  localparam logic [1:0] MODE_8BPP  = 2'd1;
  localparam logic [1:0] MODE_24BPP = 2'd2;
  localparam logic [1:0] MODE_OFF   = 2'd3;

  // item opcodes
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_DATA    = 1'b1;

  // register indexes on the apb port
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // register reset values
  localparam logic [1:0]        MODE_RST   = MODE_8BPP;
  localparam logic [CoordW-1:0] WIDTH_RST  = 12'd1;
  localparam logic [CoordW-1:0] HEIGHT_RST = 12'd1;

  // low nibble of a 4-bit byte
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  typedef struct packed {
    logic       op;
    logic [7:0] entry_index;
    logic [7:0] entry_blue;
    logic [7:0] entry_green;
    logic [7:0] entry_red;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CoordW-1:0] width;
    logic [CoordW-1:0] height;
  } cfg_t;

  // one classified job: a palette write or one/two pixels
  typedef struct packed {
    logic              is_write;
    logic              two;
    logic              direct;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [7:0]        idx0;
    logic [7:0]        idx1;
    logic [RgbW-1:0]   rgb;
  } job_t;

endpackage

`default_nettype wire

### hdl/bmpd_front.sv
`default_nettype none

module bmpd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire bmpd_pkg::cfg_t     cfg_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire bmpd_pkg::in_item_t in_data_i,
  input  wire logic            q_full_i,
  output logic                 q_push_o,
  output bmpd_pkg::job_t       q_job_o
);
  import bmpd_pkg::*;

  logic [ByteCntW-1:0] rbc_q, rbc_d;
  logic [CoordW-1:0]   row_q, row_d;
  logic [CoordW-1:0]   col_q, col_d;
  logic [1:0]          phase_q, phase_d;
  logic [7:0]          part_lo_q, part_lo_d;
  logic [7:0]          part_hi_q, part_hi_d;

  logic                acc, is_data, run, in_db, row_end;
  logic                lt0, lt1, emit0, emit1, direct;
  logic [CoordW-1:0]   width_c;
  logic [CoordW:0]     col1;
  logic [ByteCntW-1:0] db, stride, pos_nx;
  logic [7:0]          b;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && !q_full_i;
  assign is_data    = (in_data_i.op == OP_DATA);
  assign b          = in_data_i.data_byte;

  // row geometry from the current registers
  always_comb begin
    if ({2'b0, cfg_i.width} > ByteCntW'(MAX_WIDTH)) begin
      width_c = CoordW'(MAX_WIDTH);
    end else begin
      width_c = cfg_i.width;
    end
    case (cfg_i.mode)
      MODE_4BPP: begin
        db = ByteCntW'(({1'b0, width_c} + 13'd1) >> 1);
      end
      MODE_8BPP: begin
        db = ByteCntW'(width_c);
      end
      default: begin
        db = ({2'b0, width_c} << 1) + {2'b0, width_c};
      end
    endcase
    stride = (db + 14'd3) & ~14'd3;
  end

  assign run     = is_data && (cfg_i.mode != MODE_OFF) && (row_q < cfg_i.height);
  assign pos_nx  = rbc_q + 14'd1;
  assign in_db   = rbc_q < db;
  assign row_end = pos_nx >= stride;
  assign col1    = {1'b0, col_q} + 13'd1;
  assign lt0     = col_q < width_c;
  assign lt1     = col1 < {1'b0, width_c};

  // byte decode and position tracking
  always_comb begin
    rbc_d     = rbc_q;
    row_d     = row_q;
    col_d     = col_q;
    phase_d   = phase_q;
    part_lo_d = part_lo_q;
    part_hi_d = part_hi_q;
    emit0     = 1'b0;
    emit1     = 1'b0;
    direct    = 1'b0;
    if (acc && run) begin
      if (in_db) begin
        case (cfg_i.mode)
          MODE_4BPP: begin
            emit0 = lt0;
            emit1 = lt0 && lt1;
            col_d = col_q + {11'b0, emit0} + {11'b0, emit1};
          end
          MODE_8BPP: begin
            emit0 = lt0;
            col_d = col_q + {11'b0, emit0};
          end
          default: begin
            direct = 1'b1;
            case (phase_q)
              2'd0: begin
                part_lo_d = b;
                phase_d   = 2'd1;
              end
              2'd1: begin
                part_hi_d = b;
                phase_d   = 2'd2;
              end
              default: begin
                emit0     = lt0;
                col_d     = col_q + {11'b0, lt0};
                phase_d   = 2'd0;
                part_lo_d = 8'd0;
                part_hi_d = 8'd0;
              end
            endcase
          end
        endcase
      end
      if (row_end) begin
        rbc_d     = '0;
        col_d     = '0;
        phase_d   = 2'd0;
        part_lo_d = 8'd0;
        part_hi_d = 8'd0;
        row_d     = row_q + 12'd1;
      end else begin
        rbc_d = pos_nx;
      end
    end
  end

  // job for the back end
  always_comb begin
    q_push_o         = acc && (!is_data || emit0);
    q_job_o.is_write = !is_data;
    q_job_o.two      = emit1;
    q_job_o.direct   = direct;
    q_job_o.x        = col_q;
    q_job_o.y        = cfg_i.height - 12'd1 - row_q;
    q_job_o.idx1     = b & NIBBLE_MASK;
    if (!is_data) begin
      q_job_o.idx0 = in_data_i.entry_index;
      q_job_o.rgb  = {in_data_i.entry_red, in_data_i.entry_green, in_data_i.entry_blue};
    end else begin
      q_job_o.idx0 = (cfg_i.mode == MODE_4BPP) ? {4'b0, b[7:4]} : b;
      q_job_o.rgb  = {b, part_hi_q, part_lo_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbc_q     <= '0;
      row_q     <= '0;
      col_q     <= '0;
      phase_q   <= 2'd0;
      part_lo_q <= 8'd0;
      part_hi_q <= 8'd0;
    end else begin
      rbc_q     <= rbc_d;
      row_q     <= row_d;
      col_q     <= col_d;
      phase_q   <= phase_d;
      part_lo_q <= part_lo_d;
      part_hi_q <= part_hi_d;
    end
  end

endmodule

`default_nettype wire

### hdl/bmpd_queue.sv
`default_nettype none

module bmpd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bmpd_pkg::job_t job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output bmpd_pkg::job_t      head_o
);
  import bmpd_pkg::*;

  job_t           mem_q [QDepth];
  logic [QAw-1:0] wptr_q, rptr_q;
  logic [QAw:0]   cnt_q;

  assign full_o  = (cnt_q == (QAw + 1)'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/bmpd_back.sv
`default_nettype none

module bmpd_back #(
  parameter int unsigned PALETTE_DEPTH = bmpd_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire bmpd_pkg::job_t q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output bmpd_pkg::out_item_t out_data_o
);
  import bmpd_pkg::*;

  localparam int unsigned Aw = $clog2(PALETTE_DEPTH);

  // colour store, entries valid once written
  logic [RgbW-1:0]          pal_mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] pal_vld_q;

  // expansion stage
  logic              e_valid_q, e_second_q, e_two_q, e_direct_q;
  logic [CoordW-1:0] e_x_q, e_y_q;
  logic [RgbW-1:0]   e_rgb_q, rd0_q, rd1_q;
  logic              rv0_q, rv1_q;

  // output register
  logic      out_valid_q;
  out_item_t out_q;

  logic            o_free, emit, e_last, e_done, load, wr;
  logic            inr_w, inr0, inr1;
  logic [Aw-1:0]   a_w, a0, a1;
  logic [RgbW-1:0] cur_rgb;
  out_item_t       cur;

  assign o_free = !out_valid_q || out_ready_i;
  assign emit   = e_valid_q && o_free;
  assign e_last = !e_two_q || e_second_q;
  assign e_done = emit && e_last;

  assign q_pop_o = q_valid_i && (q_head_i.is_write || !e_valid_q || e_done);
  assign load    = q_pop_o && !q_head_i.is_write;
  assign wr      = q_pop_o && q_head_i.is_write;

  // palette addressing; indexes past the store read as zero
  assign inr_w = {1'b0, q_head_i.idx0} < 9'(PALETTE_DEPTH);
  assign inr0  = inr_w;
  assign inr1  = {1'b0, q_head_i.idx1} < 9'(PALETTE_DEPTH);
  assign a_w   = q_head_i.idx0[Aw-1:0];
  assign a0    = q_head_i.idx0[Aw-1:0];
  assign a1    = q_head_i.idx1[Aw-1:0];

  // palette write and both read ports
  always_ff @(posedge clk_i) begin
    if (wr && inr_w) begin
      pal_mem[a_w] <= q_head_i.rgb;
    end
    if (load) begin
      rd0_q <= pal_mem[a0];
      rd1_q <= pal_mem[a1];
      rv0_q <= inr0 && pal_vld_q[a0];
      rv1_q <= inr1 && pal_vld_q[a1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
    end else if (wr && inr_w) begin
      pal_vld_q[a_w] <= 1'b1;
    end
  end

  // job payload into the expansion stage
  always_ff @(posedge clk_i) begin
    if (load) begin
      e_two_q    <= q_head_i.two;
      e_direct_q <= q_head_i.direct;
      e_x_q      <= q_head_i.x;
      e_y_q      <= q_head_i.y;
      e_rgb_q    <= q_head_i.rgb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q  <= 1'b0;
      e_second_q <= 1'b0;
    end else if (load) begin
      e_valid_q  <= 1'b1;
      e_second_q <= 1'b0;
    end else if (e_done) begin
      e_valid_q  <= 1'b0;
      e_second_q <= 1'b0;
    end else if (emit) begin
      e_second_q <= 1'b1;
    end
  end

  // pixel currently presented by the expansion stage
  always_comb begin
    if (e_direct_q) begin
      cur_rgb = e_rgb_q;
    end else if (e_second_q) begin
      cur_rgb = rv1_q ? rd1_q : '0;
    end else begin
      cur_rgb = rv0_q ? rd0_q : '0;
    end
    cur.pixel_x = e_x_q + {11'b0, e_second_q};
    cur.pixel_y = e_y_q;
    cur.red     = cur_rgb[23:16];
    cur.green   = cur_rgb[15:8];
    cur.blue    = cur_rgb[7:0];
    cur.last    = e_last;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (o_free) begin
      out_valid_q <= emit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // second pixel only exists inside a two-pixel job
  a_second_in_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_second_q |-> (e_valid_q && e_two_q))
    else $error("second pixel flagged outside a two-pixel job");

  // the closing pixel of a job carries last
  a_last_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_done |=> (out_valid_q && out_q.last))
    else $error("job end not marked last");

  // a stalled expansion stage holds its place
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_valid_q && !emit) |=> (e_valid_q && $stable(e_second_q)))
    else $error("expansion stage moved while stalled");

  // a new pixel job never overwrites one still being sent
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!e_valid_q || e_done))
    else $error("pixel job loaded over a busy stage");

endmodule

`default_nettype wire

### hdl/bmp_row_pixel_decoder.sv
// bmp_row_pixel_decoder
// Decodes a bottom-up bmp pixel array into pixels with column, screen row and rgb.
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat is either a palette
// entry write or one byte of the pixel array. Output channel (out_valid_o/
// out_ready_i/out_data_o): one beat per pixel, last set on the final pixel of a byte.
// Mode, width and height are set on the apb port (0x0, 0x4, 0x8); the user must
// write them only while idle, since the block does not enforce it. Pixels pass from
// the queue through the expansion stage to the output register. Throughput: one byte
// per cycle in 8-bit and 24-bit modes while the receiver does not stall; in 4-bit
// mode a pixel pair goes out before the next pixel job; palette writes do not wait.
// A four-entry queue sits between the byte classifier and the palette/output end;
// a stalled receiver fills it and then drops in_ready_o.
// Reset: palette entries read as zero, position counters clear, mode is 8-bit,
// width and height are 1. No clearing pass is needed after reset.
`default_nettype none

module bmp_row_pixel_decoder #(
  parameter int unsigned PALETTE_DEPTH = bmpd_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire bmpd_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output bmpd_pkg::out_item_t      out_data_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import bmpd_pkg::*;

  cfg_t cfg_q;
  logic cfg_wr;
  logic q_push, q_full, q_pop, q_valid;
  job_t q_job, q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= MODE_RST;
      cfg_q.width  <= WIDTH_RST;
      cfg_q.height <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MODE:   cfg_q.mode   <= pwdata[1:0];
        REG_WIDTH:  cfg_q.width  <= pwdata[CoordW-1:0];
        REG_HEIGHT: cfg_q.height <= pwdata[CoordW-1:0];
        default:    cfg_q        <= cfg_q;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_MODE:   prdata = {30'b0, cfg_q.mode};
      REG_WIDTH:  prdata = {20'b0, cfg_q.width};
      REG_HEIGHT: prdata = {20'b0, cfg_q.height};
      default:    prdata = '0;
    endcase
  end

  bmpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_job)
  );

  bmpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  bmpd_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
